FILE: rtl/core/oaids_pkg.sv
package oaids_pkg;

  // Number of cells in the chain, one stored entry each.
  localparam int CAPACITY = 64;
  // A dump emits at most this many items.
  localparam int MAX_RESULTS = 64;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  // The search result is located a group of eight cells per cycle.
  localparam int GRP_SIZE = 8;
  localparam int NGRP = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int SIDX_W = GRP_W + 3;

  localparam int REQ_W = 3;
  localparam int POS_W = 6;
  localparam int DATA_W = 32;
  localparam int STATUS_W = 3;
  localparam int OIDX_W = 6;
  localparam int FILL_W = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 3'd0,
    REQ_APPEND = 3'd1,
    REQ_DUMP   = 3'd2,
    REQ_INSERT = 3'd3,
    REQ_DELETE = 3'd4,
    REQ_SEARCH = 3'd5
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_INSERT  = 3'd1,
    CELL_DELETE  = 3'd2,
    CELL_ROTATE  = 3'd3,
    CELL_COMPARE = 3'd4
  } cell_op_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    cell_op_t                 op;
    logic [CNT_W-1:0]         pos;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

FILE: rtl/core/oaids_cell.sv
module oaids_cell (
  input  logic                               clk,
  input  oaids_pkg::cell_cmd_t               cmd,
  input  logic [oaids_pkg::CNT_W-1:0]        my_index,
  input  logic signed [oaids_pkg::DATA_W-1:0] prev_data,
  input  logic signed [oaids_pkg::DATA_W-1:0] next_data,
  output logic signed [oaids_pkg::DATA_W-1:0] data,
  output logic                               match
);

  // Each cell decides from its own index whether it shifts, loads or holds.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      oaids_pkg::CELL_INSERT: begin
        if (my_index > cmd.pos) begin
          data <= prev_data;
        end else if (my_index == cmd.pos) begin
          data <= cmd.value;
        end
      end
      oaids_pkg::CELL_DELETE: begin
        if (my_index >= cmd.pos) begin
          data <= next_data;
        end
      end
      oaids_pkg::CELL_ROTATE: begin
        data <= next_data;
      end
      oaids_pkg::CELL_COMPARE: begin
        match <= (data == cmd.value) && (my_index < cmd.count);
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/ordered_array_insert_delete_search.sv
// Ordered array of signed 32-bit entries kept in a chain of 64 cells. Clear,
// append, insert, delete and unknown requests, and a dump or search of an empty
// array, are taken with busy staying low, and their single result item appears
// on the cycle after start. Any other dump rotates the whole chain once through
// cell 0 while busy is high, and the stored entries come out as items on
// consecutive cycles, the final one flagged by last. Any other search compares
// every cell in the start cycle and then scans the match flags eight cells per
// cycle, stopping at the first group with a match. Each item is shown for exactly
// one cycle with result_valid high; the receiver cannot hold it off, so it must
// capture every item in the cycle it is shown.
module ordered_array_insert_delete_search (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [oaids_pkg::REQ_W-1:0]        req_type,
  input  logic [oaids_pkg::POS_W-1:0]        position,
  input  logic signed [oaids_pkg::DATA_W-1:0] value,
  output logic                               result_valid,
  output logic [oaids_pkg::STATUS_W-1:0]     status,
  output logic [oaids_pkg::OIDX_W-1:0]       index,
  output logic signed [oaids_pkg::DATA_W-1:0] element,
  output logic [oaids_pkg::FILL_W-1:0]       fill_count,
  output logic                               last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DUMP = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state, state_next;
  logic [oaids_pkg::CNT_W-1:0] count, count_next;
  logic [oaids_pkg::IDX_W-1:0] rot, rot_next;
  logic [oaids_pkg::GRP_W-1:0] grp, grp_next;

  oaids_pkg::cell_cmd_t cmd;
  logic signed [oaids_pkg::DATA_W-1:0] cell_data [oaids_pkg::CAPACITY];
  logic [oaids_pkg::CAPACITY-1:0] cell_match;
  logic [oaids_pkg::NGRP*oaids_pkg::GRP_SIZE-1:0] match_vec;

  logic                             emit;
  oaids_pkg::status_t               emit_status;
  logic [oaids_pkg::SIDX_W-1:0]     emit_index;
  logic [oaids_pkg::CMP_W-1:0]      emit_index_dump;
  logic                             emit_from_dump;
  logic signed [oaids_pkg::DATA_W-1:0] emit_element;
  logic                             emit_last;

  logic                             accept;
  logic [oaids_pkg::CMP_W-1:0]      pos_ext;
  logic [oaids_pkg::CMP_W-1:0]      cnt_ext;
  logic [oaids_pkg::CMP_W-1:0]      dump_n;
  logic                             is_full;
  logic [oaids_pkg::GRP_SIZE-1:0]   grp_bits;
  logic [2:0]                       grp_low;

  for (genvar i = 0; i < oaids_pkg::CAPACITY; i++) begin : g_cell
    oaids_cell u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .my_index  (oaids_pkg::CNT_W'(i)),
      .prev_data ((i == 0) ? value :
                  cell_data[(i + oaids_pkg::CAPACITY - 1) % oaids_pkg::CAPACITY]),
      .next_data (cell_data[(i + 1) % oaids_pkg::CAPACITY]),
      .data      (cell_data[i]),
      .match     (cell_match[i])
    );
  end

  always_comb begin
    match_vec = '0;
    for (int i = 0; i < oaids_pkg::CAPACITY; i++) begin
      match_vec[i] = cell_match[i];
    end
  end

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign pos_ext = oaids_pkg::CMP_W'(position);
  assign cnt_ext = oaids_pkg::CMP_W'(count);
  assign is_full = (cnt_ext == oaids_pkg::CMP_W'(oaids_pkg::CAPACITY));
  assign dump_n  = (cnt_ext > oaids_pkg::CMP_W'(oaids_pkg::MAX_RESULTS)) ?
                   oaids_pkg::CMP_W'(oaids_pkg::MAX_RESULTS) : cnt_ext;

  // Lowest set flag within the current group of eight cells.
  assign grp_bits = match_vec[grp*oaids_pkg::GRP_SIZE +: oaids_pkg::GRP_SIZE];
  always_comb begin
    grp_low = 3'd0;
    for (int b = oaids_pkg::GRP_SIZE - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        grp_low = 3'(b);
      end
    end
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    rot_next        = rot;
    grp_next        = grp;
    cmd.op          = oaids_pkg::CELL_HOLD;
    cmd.pos         = oaids_pkg::CNT_W'(position);
    cmd.count       = count;
    cmd.value       = value;
    emit            = 1'b0;
    emit_status     = oaids_pkg::ST_OK;
    emit_index      = '0;
    emit_index_dump = '0;
    emit_from_dump  = 1'b0;
    emit_element    = '0;
    emit_last       = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          emit = 1'b1;
          unique case (req_type)
            oaids_pkg::REQ_CLEAR: begin
              count_next = '0;
            end
            oaids_pkg::REQ_APPEND: begin
              if (is_full) begin
                emit_status = oaids_pkg::ST_FULL;
              end else begin
                cmd.op     = oaids_pkg::CELL_INSERT;
                cmd.pos    = count;
                count_next = count + 1'b1;
              end
            end
            oaids_pkg::REQ_DUMP: begin
              if (count == '0) begin
                emit_status = oaids_pkg::ST_EMPTY;
              end else begin
                emit       = 1'b0;
                rot_next   = '0;
                state_next = S_DUMP;
              end
            end
            oaids_pkg::REQ_INSERT: begin
              if (is_full) begin
                emit_status = oaids_pkg::ST_FULL;
              end else if (pos_ext > cnt_ext) begin
                emit_status = oaids_pkg::ST_BADPOS;
              end else begin
                cmd.op     = oaids_pkg::CELL_INSERT;
                count_next = count + 1'b1;
              end
            end
            oaids_pkg::REQ_DELETE: begin
              if (count == '0) begin
                emit_status = oaids_pkg::ST_EMPTY;
              end else if (pos_ext >= cnt_ext) begin
                emit_status = oaids_pkg::ST_BADPOS;
              end else begin
                cmd.op     = oaids_pkg::CELL_DELETE;
                count_next = count - 1'b1;
              end
            end
            oaids_pkg::REQ_SEARCH: begin
              if (count == '0) begin
                emit_status = oaids_pkg::ST_EMPTY;
              end else begin
                emit       = 1'b0;
                cmd.op     = oaids_pkg::CELL_COMPARE;
                grp_next   = '0;
                state_next = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        // Cell 0 holds entry rot; the full rotation restores the order.
        cmd.op         = oaids_pkg::CELL_ROTATE;
        rot_next       = rot + 1'b1;
        emit_from_dump = 1'b1;
        emit_index_dump = oaids_pkg::CMP_W'(rot);
        if (oaids_pkg::CMP_W'(rot) < dump_n) begin
          emit         = 1'b1;
          emit_element = cell_data[0];
          emit_last    = (oaids_pkg::CMP_W'(rot) + 1'b1 == dump_n);
        end
        if (rot == oaids_pkg::IDX_W'(oaids_pkg::CAPACITY - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        grp_next = grp + 1'b1;
        if (grp_bits != '0) begin
          emit       = 1'b1;
          emit_index = {grp, grp_low};
          state_next = S_IDLE;
        end else if (grp == oaids_pkg::GRP_W'(oaids_pkg::NGRP - 1)) begin
          emit        = 1'b1;
          emit_status = oaids_pkg::ST_NOTFOUND;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      rot          <= '0;
      grp          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      rot          <= rot_next;
      grp          <= grp_next;
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    status     <= emit_status;
    index      <= emit_from_dump ? oaids_pkg::OIDX_W'(emit_index_dump)
                                 : oaids_pkg::OIDX_W'(emit_index);
    element    <= emit_element;
    fill_count <= oaids_pkg::FILL_W'(count_next);
    last       <= emit_last;
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  // Request codes the block does not decode; it answers them with a plain ok.
  localparam logic [oaids_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [oaids_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  typedef struct {
    oaids_pkg::status_t                  status;
    logic [oaids_pkg::OIDX_W-1:0]        index;
    logic signed [oaids_pkg::DATA_W-1:0] element;
    logic [oaids_pkg::FILL_W-1:0]        fill;
    logic                                last;
  } array_result_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                start;
  logic                                busy;
  logic [oaids_pkg::REQ_W-1:0]         req_type;
  logic [oaids_pkg::POS_W-1:0]         position;
  logic signed [oaids_pkg::DATA_W-1:0] value;
  logic                                result_valid;
  logic [oaids_pkg::STATUS_W-1:0]      status;
  logic [oaids_pkg::OIDX_W-1:0]        index;
  logic signed [oaids_pkg::DATA_W-1:0] element;
  logic [oaids_pkg::FILL_W-1:0]        fill_count;
  logic                                last;

  // Shadow copy of the array, updated as each item is accepted.
  logic signed [oaids_pkg::DATA_W-1:0] shadow_entries [oaids_pkg::CAPACITY];
  int                                  shadow_count;
  array_result_t                       expected_results [$];
  int                                  mismatches;
  int                                  send_gap_pct;

  ordered_array_insert_delete_search u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .position     (position),
    .value        (value),
    .result_valid (result_valid),
    .status       (status),
    .index        (index),
    .element      (element),
    .fill_count   (fill_count),
    .last         (last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void push_result(oaids_pkg::status_t st, int idx,
                                      logic signed [oaids_pkg::DATA_W-1:0] elem,
                                      logic fin);
    array_result_t r;
    r.status  = st;
    r.index   = oaids_pkg::OIDX_W'(idx);
    r.element = elem;
    r.fill    = oaids_pkg::FILL_W'(shadow_count);
    r.last    = fin;
    expected_results.push_back(r);
  endfunction

  // Applies one request to the shadow array and queues the items it produces.
  function automatic void apply_request(logic [oaids_pkg::REQ_W-1:0] req,
                                        logic [oaids_pkg::POS_W-1:0] pos,
                                        logic signed [oaids_pkg::DATA_W-1:0] val);
    int n;
    int hit;
    case (req)
      oaids_pkg::REQ_CLEAR: begin
        shadow_count = 0;
        push_result(oaids_pkg::ST_OK, 0, '0, 1'b1);
      end
      oaids_pkg::REQ_APPEND: begin
        if (shadow_count >= oaids_pkg::CAPACITY) begin
          push_result(oaids_pkg::ST_FULL, 0, '0, 1'b1);
        end else begin
          shadow_entries[shadow_count] = val;
          shadow_count++;
          push_result(oaids_pkg::ST_OK, 0, '0, 1'b1);
        end
      end
      oaids_pkg::REQ_DUMP: begin
        n = (shadow_count < oaids_pkg::MAX_RESULTS) ? shadow_count : oaids_pkg::MAX_RESULTS;
        if (n == 0) begin
          push_result(oaids_pkg::ST_EMPTY, 0, '0, 1'b1);
        end
        for (int i = 0; i < n; i++) begin
          push_result(oaids_pkg::ST_OK, i, shadow_entries[i], i == n - 1);
        end
      end
      oaids_pkg::REQ_INSERT: begin
        if (shadow_count >= oaids_pkg::CAPACITY) begin
          push_result(oaids_pkg::ST_FULL, 0, '0, 1'b1);
        end else if (int'(pos) > shadow_count) begin
          push_result(oaids_pkg::ST_BADPOS, 0, '0, 1'b1);
        end else begin
          for (int i = shadow_count; i > int'(pos); i--) begin
            shadow_entries[i] = shadow_entries[i - 1];
          end
          shadow_entries[pos] = val;
          shadow_count++;
          push_result(oaids_pkg::ST_OK, 0, '0, 1'b1);
        end
      end
      oaids_pkg::REQ_DELETE: begin
        if (shadow_count == 0) begin
          push_result(oaids_pkg::ST_EMPTY, 0, '0, 1'b1);
        end else if (int'(pos) >= shadow_count) begin
          push_result(oaids_pkg::ST_BADPOS, 0, '0, 1'b1);
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
          end
          shadow_count--;
          push_result(oaids_pkg::ST_OK, 0, '0, 1'b1);
        end
      end
      oaids_pkg::REQ_SEARCH: begin
        hit = -1;
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_entries[i] == val) hit = i;
        end
        if (shadow_count == 0) begin
          push_result(oaids_pkg::ST_EMPTY, 0, '0, 1'b1);
        end else if (hit < 0) begin
          push_result(oaids_pkg::ST_NOTFOUND, 0, '0, 1'b1);
        end else begin
          push_result(oaids_pkg::ST_OK, hit, '0, 1'b1);
        end
      end
      default: begin
        push_result(oaids_pkg::ST_OK, 0, '0, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Holds the item on the inputs until the block takes it. Inputs only move at
  // rising edges, so the value of busy at the falling edge is the one the
  // next rising edge sees. Each cycle after the item is idle with a chance of
  // send_gap_pct in a hundred.
  task automatic send_item(input logic [oaids_pkg::REQ_W-1:0] req,
                           input logic [oaids_pkg::POS_W-1:0] pos,
                           input logic signed [oaids_pkg::DATA_W-1:0] val);
    start    <= 1'b1;
    req_type <= req;
    position <= pos;
    value    <= val;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
    apply_request(req, pos, val);
    if ($urandom_range(99) < send_gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
  endtask

  always @(negedge clk) begin : result_check
    array_result_t want;
    if (!rst && result_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result item with nothing outstanding");
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (index !== want.index)
          report_mismatch($sformatf("index %0d, expected %0d", index, want.index));
        if (element !== want.element)
          report_mismatch($sformatf("element %0d, expected %0d", element, want.element));
        if (fill_count !== want.fill)
          report_mismatch($sformatf("fill_count %0d, expected %0d", fill_count, want.fill));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
      end
    end
  end

  task automatic test_empty_array();
    send_item(oaids_pkg::REQ_DUMP, '0, '0);
    send_item(oaids_pkg::REQ_DELETE, '0, '0);
    send_item(oaids_pkg::REQ_SEARCH, '1, 32'sd7);
    send_item(oaids_pkg::REQ_CLEAR, '0, '0);
    send_item(REQ_SPARE_LO, '1, '1);
    send_item(REQ_SPARE_HI, '0, '0);
  endtask

  task automatic test_edit_edges();
    send_item(oaids_pkg::REQ_APPEND, '0, 32'sh7fffffff);
    send_item(oaids_pkg::REQ_APPEND, '0, 32'sh80000000);
    send_item(oaids_pkg::REQ_APPEND, '0, '0);
    send_item(oaids_pkg::REQ_APPEND, '0, -32'sd1);
    send_item(oaids_pkg::REQ_INSERT, 6'd0, 32'sd5);
    send_item(oaids_pkg::REQ_INSERT, 6'd5, 32'sh7fffffff);
    send_item(oaids_pkg::REQ_INSERT, 6'd7, 32'sd9);
    send_item(oaids_pkg::REQ_INSERT, 6'd63, 32'sd9);
    // The maximum value is now stored twice; the lower index must win.
    send_item(oaids_pkg::REQ_SEARCH, '0, 32'sh7fffffff);
    send_item(oaids_pkg::REQ_SEARCH, '0, 32'sd12345);
    send_item(oaids_pkg::REQ_DELETE, 6'd6, '0);
    send_item(oaids_pkg::REQ_DELETE, 6'd63, '0);
    send_item(oaids_pkg::REQ_DELETE, 6'd0, '0);
    send_item(oaids_pkg::REQ_DELETE, 6'd4, '0);
    send_item(oaids_pkg::REQ_DUMP, '0, '0);
    send_item(oaids_pkg::REQ_SEARCH, '0, -32'sd1);
  endtask

  task automatic test_fill_to_capacity();
    send_item(oaids_pkg::REQ_CLEAR, '0, '0);
    while (shadow_count < oaids_pkg::CAPACITY) send_item(oaids_pkg::REQ_APPEND, '0, $urandom);
    send_item(oaids_pkg::REQ_APPEND, '0, $urandom);
    // A full array refuses an insert before the position is looked at.
    send_item(oaids_pkg::REQ_INSERT, 6'd63, $urandom);
    send_item(oaids_pkg::REQ_INSERT, 6'd0, $urandom);
    send_item(oaids_pkg::REQ_SEARCH, '0, shadow_entries[oaids_pkg::CAPACITY - 1]);
    send_item(oaids_pkg::REQ_SEARCH, '0, $urandom);
    send_item(oaids_pkg::REQ_DUMP, '0, '0);
    send_item(oaids_pkg::REQ_DELETE, 6'd63, '0);
    send_item(oaids_pkg::REQ_INSERT, 6'd63, $urandom);
    send_item(oaids_pkg::REQ_DELETE, 6'd0, '0);
    send_item(oaids_pkg::REQ_DELETE, 6'd63, '0);
  endtask

  task automatic test_random_traffic(input int n_items);
    int                                  roll;
    logic [oaids_pkg::REQ_W-1:0]         req;
    logic [oaids_pkg::POS_W-1:0]         pos;
    logic signed [oaids_pkg::DATA_W-1:0] val;
    for (int k = 0; k < n_items; k++) begin
      roll = $urandom_range(99);
      if (roll < 24) req = oaids_pkg::REQ_APPEND;
      else if (roll < 44) req = oaids_pkg::REQ_INSERT;
      else if (roll < 64) req = oaids_pkg::REQ_DELETE;
      else if (roll < 86) req = oaids_pkg::REQ_SEARCH;
      else if (roll < 93) req = oaids_pkg::REQ_DUMP;
      else if (roll < 96) req = oaids_pkg::REQ_CLEAR;
      else req = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;

      pos = oaids_pkg::POS_W'($urandom_range(63));
      if ($urandom_range(99) < 85) begin
        if (req == oaids_pkg::REQ_DELETE && shadow_count > 0)
          pos = oaids_pkg::POS_W'($urandom_range(shadow_count - 1));
        else if (req == oaids_pkg::REQ_INSERT)
          pos = oaids_pkg::POS_W'($urandom_range((shadow_count > 63) ? 63 : shadow_count));
      end

      val = $urandom;
      if (shadow_count > 0 &&
          $urandom_range(99) < ((req == oaids_pkg::REQ_SEARCH) ? 60 : 20))
        val = shadow_entries[$urandom_range(shadow_count - 1)];

      send_item(req, pos, val);
    end
  endtask

  initial begin
    mismatches    = 0;
    shadow_count  = 0;
    send_gap_pct  = 30;
    rst      <= 1'b1;
    start    <= 1'b0;
    req_type <= '0;
    position <= '0;
    value    <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_array();
    test_edit_edges();
    test_random_traffic(5);
    send_gap_pct = 48;
    test_fill_to_capacity();
    test_random_traffic(4);
    send_gap_pct = 0;
    test_random_traffic(4);

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
